[rtl/mbd_pkg.sv]
`default_nettype none

package mbd_pkg;

    // Level size limits and row store geometry
    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);

    // Pixel channels and pair sums
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 4;
    localparam int PAIR_W  = CH_W + 1;
    localparam int STORE_W = NUM_CH * PAIR_W;
    localparam int NACT_W  = $clog2(NUM_CH + 1);

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int FMT_W     = 2;
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4096);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 2'd2;

    // Pixel format codes
    localparam logic [FMT_W-1:0] FMT_ONE  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_TWO  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_FOUR = 2'd2;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        OP_WRITE,
        OP_READ
    } op_t;

    typedef logic [PAIR_W-1:0] pair_t;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        pair_t [NUM_CH-1:0]      pair;
        logic [FMT_W-1:0]        fmt;
        logic                    last;
    } job_t;

    // Round a size down to even and clamp it to 2..maxv
    function automatic logic [CFG_W-1:0] fit_size(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] e;
        e = {v[CFG_W-1:1], 1'b0};
        if (e < CFG_W'(2))
        begin
            e = CFG_W'(2);
        end
        if (32'(e) > 32'(maxv))
        begin
            e = CFG_W'(maxv);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/mbd_ram.sv]
`default_nettype none

module mbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/mbd_front.sv]
`default_nettype none

module mbd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c0,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c1,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c2,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c3,
    input  wire logic                          queue_full,
    output logic                               push,
    output mbd_pkg::job_t                      job
);

    import mbd_pkg::*;

    logic [FMT_W-1:0]                fmt_reg,    fmt_next;
    logic [CFG_W-1:0]                width_reg,  width_next;
    logic [CFG_W-1:0]                height_reg, height_next;
    logic [COL_W-1:0]                col_reg,    col_next;
    logic [ROW_W-1:0]                row_reg,    row_next;
    logic [NUM_CH-1:0][CH_W-1:0]     held_reg,   held_next;

    logic [CFG_W-1:0]                w;
    logic [CFG_W-1:0]                h;
    logic [COL_W-1:0]                col_eff;
    logic [ROW_W-1:0]                row_eff;
    logic [COL_W:0]                  col_inc;
    logic [ROW_W:0]                  row_inc;
    logic [NUM_CH-1:0][CH_W-1:0]     pix;
    logic                            accept;

    assign pix      = {pix_c3, pix_c2, pix_c1, pix_c0};
    assign accept   = in_valid && !queue_full;
    assign in_stall = queue_full;

    // Effective size and position; a stale count past the size wraps to zero
    always_comb
    begin
        w       = fit_size(width_reg, MAX_WIDTH);
        h       = fit_size(height_reg, MAX_HEIGHT);
        col_eff = (32'(col_reg) >= 32'(w)) ? '0 : col_reg;
        row_eff = (32'(row_reg) >= 32'(h)) ? '0 : row_reg;
    end

    // Classify the pixel: right pixel of a pair becomes a store write or a read
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            job.pair[k] = PAIR_W'(held_reg[k]) + PAIR_W'(pix[k]);
        end
        job.op   = row_eff[0] ? OP_READ : OP_WRITE;
        job.idx  = col_eff[COL_W-1:1];
        job.fmt  = fmt_reg;
        job.last = (32'(row_eff) == 32'(h) - 32'd1) && (32'(col_eff) == 32'(w) - 32'd1);
        push     = accept && col_eff[0];
    end

    // Next state: config writes, held pixel, raster counters
    always_comb
    begin
        fmt_next    = fmt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        held_next   = held_reg;
        col_inc     = {1'b0, col_eff} + 1'b1;
        row_inc     = {1'b0, row_eff} + 1'b1;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_PIXEL_FORMAT: fmt_next    = cfg_data[FMT_W-1:0];
                REG_SRC_WIDTH:    width_next  = cfg_data;
                REG_SRC_HEIGHT:   height_next = cfg_data;
                default:          ;
            endcase
        end

        if (accept)
        begin
            if (!col_eff[0])
            begin
                held_next = pix;
            end
            if (32'(col_inc) >= 32'(w))
            begin
                col_next = '0;
                row_next = (32'(row_inc) >= 32'(h)) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_FOUR;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
        end
        else
        begin
            fmt_reg    <= fmt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            held_reg   <= held_next;
        end
    end

    // The final output pixel always comes from a store read
    a_last_is_read: assert property (@(posedge clk) disable iff (!rst_n)
        push && job.last |-> job.op == OP_READ)
        else $error("last pixel flagged on a store write");

    // Left pixel of a pair is captured for the next transfer
    a_held_capture: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !col_eff[0] |=> held_reg == $past(pix))
        else $error("held pixel not captured");

endmodule

`default_nettype wire

[rtl/mbd_queue.sv]
`default_nettype none

module mbd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mbd_pkg::job_t job_in,
    output logic               full,
    input  wire logic          pop,
    output mbd_pkg::job_t      job_out,
    output logic               empty
);

    import mbd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("job queue overflow");

endmodule

`default_nettype wire

[rtl/mbd_back.sv]
`default_nettype none

module mbd_back (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mbd_pkg::job_t            job,
    input  wire logic                     empty,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [mbd_pkg::CH_W-1:0]      out_c0,
    output logic [mbd_pkg::CH_W-1:0]      out_c1,
    output logic [mbd_pkg::CH_W-1:0]      out_c2,
    output logic [mbd_pkg::CH_W-1:0]      out_c3,
    output logic                          last_pixel
);

    import mbd_pkg::*;

    logic                          s1_valid_reg, s1_valid_next;
    pair_t [NUM_CH-1:0]            s1_pair_reg,  s1_pair_next;
    logic [FMT_W-1:0]              s1_fmt_reg,   s1_fmt_next;
    logic                          s1_last_reg,  s1_last_next;
    logic                          out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0][CH_W-1:0]   out_ch_reg,   out_ch_next;
    logic                          out_last_reg, out_last_next;

    logic                          ram_we;
    logic                          ram_re;
    logic [STORE_W-1:0]            ram_wdata;
    logic [STORE_W-1:0]            ram_rdata;
    pair_t [NUM_CH-1:0]            stored;
    logic [PAIR_W:0]               sum [NUM_CH];
    logic [NUM_CH-1:0][CH_W-1:0]   avg;
    logic [NACT_W-1:0]             n_act;
    logic                          out_free;
    logic                          s1_move;
    logic                          s1_free;

    // Row store of even-row pair sums
    mbd_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (job.idx),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (job.idx),
        .rdata (ram_rdata)
    );

    assign ram_wdata = job.pair;
    assign stored    = ram_rdata;

    // Issue: writes go straight to the store, reads need a free read stage
    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        s1_move  = s1_valid_reg && out_free;
        s1_free  = !s1_valid_reg || s1_move;
        pop      = !empty && ((job.op == OP_WRITE) || s1_free);
        ram_we   = pop && (job.op == OP_WRITE);
        ram_re   = pop && (job.op == OP_READ);
    end

    // Complete the 2x2 sums, divide by four and mask inactive channels
    always_comb
    begin
        case (s1_fmt_reg)
            FMT_ONE: n_act = NACT_W'(1);
            FMT_TWO: n_act = NACT_W'(2);
            default: n_act = NACT_W'(NUM_CH);
        endcase
        for (int k = 0; k < NUM_CH; k++)
        begin
            sum[k] = {1'b0, stored[k]} + {1'b0, s1_pair_reg[k]};
            avg[k] = (32'(k) < 32'(n_act)) ? sum[k][PAIR_W:2] : '0;
        end
    end

    // Next state of the read stage and the output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_pair_next   = s1_pair_reg;
        s1_fmt_next    = s1_fmt_reg;
        s1_last_next   = s1_last_reg;
        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_last_next  = out_last_reg;

        if (ram_re)
        begin
            s1_valid_next = 1'b1;
            s1_pair_next  = job.pair;
            s1_fmt_next   = job.fmt;
            s1_last_next  = job.last;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_move)
        begin
            out_valid_next = 1'b1;
            out_ch_next    = avg;
            out_last_next  = s1_last_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pair_reg  <= s1_pair_next;
        s1_fmt_reg   <= s1_fmt_next;
        s1_last_reg  <= s1_last_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_c0     = out_ch_reg[0];
    assign out_c1     = out_ch_reg[1];
    assign out_c2     = out_ch_reg[2];
    assign out_c3     = out_ch_reg[3];
    assign last_pixel = out_last_reg;

    // A blocked read stage keeps its pair sums for the held store data
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_pair_reg))
        else $error("read stage lost while output blocked");

    // A completed read always lands in the output register
    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result dropped between read stage and output");

endmodule

`default_nettype wire

[rtl/mipmap_box_downsample_top.sv]
// 2x2 box-filter mipmap downsampler.
// Input channel (in_valid / in_stall, pix_c0..pix_c3): one source pixel per
// transfer, raster order. Output channel (out_valid / out_stall, out_c0..3,
// last_pixel): one pixel of the half-size level per 2x2 source block, on the
// right pixel of each pair in an odd source row; last_pixel marks the final one.
// Configuration: cfg_write_en with cfg_index 0 pixel_format, 1 src_width,
// 2 src_height; write only while no pixel is in flight.
// Throughput: one source pixel per cycle while out_stall stays low. A
// result passes the job queue entry, then the row store's registered read
// with the read stage, then the output register.
// The front tracks position and forms pair sums; a four-entry job queue feeds
// the back, which writes or reads the row store (one port each) and adds.
// When out_stall is high the output register holds, the back stops issuing
// reads once its read stage is full, and once the queue is full in_stall rises.
// Reset: counters and held pixel clear, format four channels, size 4096x4096.
// Row store not cleared; the user must ensure every entry is written before it is read, unenforced.
`default_nettype none

module mipmap_box_downsample_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbd_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c0,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c1,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c2,
    input  wire logic [mbd_pkg::CH_W-1:0]      pix_c3,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mbd_pkg::CH_W-1:0]           out_c0,
    output logic [mbd_pkg::CH_W-1:0]           out_c1,
    output logic [mbd_pkg::CH_W-1:0]           out_c2,
    output logic [mbd_pkg::CH_W-1:0]           out_c3,
    output logic                               last_pixel
);

    import mbd_pkg::*;

    job_t   front_job;
    job_t   back_job;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;

    // Front: config, position tracking, pair sums
    mbd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pix_c0       (pix_c0),
        .pix_c1       (pix_c1),
        .pix_c2       (pix_c2),
        .pix_c3       (pix_c3),
        .queue_full   (full),
        .push         (push),
        .job          (front_job)
    );

    // Job queue
    mbd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (front_job),
        .full    (full),
        .pop     (pop),
        .job_out (back_job),
        .empty   (empty)
    );

    // Back: row store access, averaging, output register
    mbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (back_job),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_c0     (out_c0),
        .out_c1     (out_c1),
        .out_c2     (out_c2),
        .out_c3     (out_c3),
        .last_pixel (last_pixel)
    );

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

import mbd_pkg::*;

typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

typedef struct packed {
    pixel_t ch;
    logic   last;
} box_px_t;

// Tracks the source position and the row of pair sums, predicts each box pixel
class mip_scoreboard;
    logic [FMT_W-1:0]                   fmt;
    logic [CFG_W-1:0]                   width_reg;
    logic [CFG_W-1:0]                   height_reg;
    int                                 col;
    int                                 row;
    pixel_t                             held;
    logic [NUM_CH-1:0][PAIR_W-1:0]      pair_sums [STORE_DEPTH];
    bit                                 stored [STORE_DEPTH];
    box_px_t                            box_due [$];
    int                                 errors;
    int                                 pixels_in;
    int                                 checked;
    int                                 level_ends;
    int                                 reg_writes;

    function new();
        fmt        = FMT_FOUR;
        width_reg  = SIZE_RESET;
        height_reg = SIZE_RESET;
        col        = 0;
        row        = 0;
        held       = '0;
        errors     = 0;
        pixels_in  = 0;
        checked    = 0;
        level_ends = 0;
        reg_writes = 0;
    endfunction

    // Round down to even, then clamp to 2..hi
    function int even_clamp(logic [CFG_W-1:0] v, int hi);
        int e;
        e = int'(v) & ~1;
        if (e < 2)
        begin
            e = 2;
        end
        if (e > hi)
        begin
            e = hi;
        end
        return e;
    endfunction

    function int active_count();
        if (fmt == FMT_ONE)
        begin
            return 1;
        end
        if (fmt == FMT_TWO)
        begin
            return 2;
        end
        return 4;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        reg_writes++;
        case (idx)
            REG_PIXEL_FORMAT: fmt = data[FMT_W-1:0];
            REG_SRC_WIDTH:    width_reg = data;
            REG_SRC_HEIGHT:   height_reg = data;
            default:          ;
        endcase
    endfunction

    function int pending();
        return box_due.size();
    endfunction

    // True when every row store entry read under this size was written before
    function bit reads_covered(logic [CFG_W-1:0] w_v, logic [CFG_W-1:0] h_v);
        int w;
        int h;
        int c;
        int r;
        int lo;
        int hi;
        w = even_clamp(w_v, MAX_WIDTH);
        h = even_clamp(h_v, MAX_HEIGHT);
        c = (col >= w) ? 0 : col;
        r = (row >= h) ? 0 : row;
        if (r % 2 == 1)
        begin
            lo = c >> 1;
            hi = w / 2;
        end
        else
        begin
            lo = 0;
            hi = c >> 1;
        end
        for (int i = lo; i < hi; i++)
        begin
            if (!stored[i])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function int pixels_to_level_end(logic [CFG_W-1:0] w_v, logic [CFG_W-1:0] h_v);
        int w;
        int h;
        int c;
        int r;
        w = even_clamp(w_v, MAX_WIDTH);
        h = even_clamp(h_v, MAX_HEIGHT);
        c = (col >= w) ? 0 : col;
        r = (row >= h) ? 0 : row;
        return (h - r) * w - c;
    endfunction

    // Accepted source pixel: update position, pair sums and expected output
    function void take_pixel(pixel_t p);
        int w;
        int h;
        int c;
        int r;
        int idx;
        logic [PAIR_W-1:0] pr;
        logic [PAIR_W:0]   total;
        box_px_t           want;
        pixels_in++;
        w = even_clamp(width_reg, MAX_WIDTH);
        h = even_clamp(height_reg, MAX_HEIGHT);
        c = (col >= w) ? 0 : col;
        r = (row >= h) ? 0 : row;
        if (c % 2 == 0)
        begin
            held = p;
        end
        else
        begin
            idx = c >> 1;
            if (idx >= STORE_DEPTH)
            begin
                idx = STORE_DEPTH - 1;
            end
            want = '0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                pr = {1'b0, held[k]} + {1'b0, p[k]};
                if (r % 2 == 0)
                begin
                    pair_sums[idx][k] = pr;
                end
                else
                begin
                    total = {1'b0, pair_sums[idx][k]} + {1'b0, pr};
                    want.ch[k] = (k < active_count()) ? total[PAIR_W:2] : '0;
                end
            end
            if (r % 2 == 0)
            begin
                stored[idx] = 1'b1;
            end
            else
            begin
                want.last = (r == h - 1) && (c == w - 1);
                box_due.push_back(want);
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col = c;
        row = r;
    endfunction

    // Accepted box pixel: compare with the oldest prediction
    function void check_pixel(box_px_t got);
        box_px_t want;
        if (box_due.size() == 0)
        begin
            $display("%0t: box pixel with none expected: ch=%h last=%b",
                     $time, got.ch, got.last);
            errors++;
            return;
        end
        want = box_due.pop_front();
        checked++;
        for (int k = 0; k < NUM_CH; k++)
        begin
            if (got.ch[k] !== want.ch[k])
            begin
                $display("%0t: out_c%0d expected %0d, actual %0d",
                         $time, k, want.ch[k], got.ch[k]);
                errors++;
            end
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last_pixel expected %b, actual %b", $time, want.last, got.last);
            errors++;
        end
        if (want.last)
        begin
            level_ends++;
        end
    endfunction
endclass

module tb;

    localparam logic [FMT_W-1:0]     FMT_SPARE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam int                   RANDOM_PIXELS = 1200;
    localparam int                   WIDE_PIXELS   = 256;
    localparam int                   DRAIN_CYCLES  = 10;
    localparam int                   IDLE_LIMIT    = 2000;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [CH_W-1:0]      pix_c0       = '0;
    logic [CH_W-1:0]      pix_c1       = '0;
    logic [CH_W-1:0]      pix_c2       = '0;
    logic [CH_W-1:0]      pix_c3       = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [CH_W-1:0]      out_c0;
    logic [CH_W-1:0]      out_c1;
    logic [CH_W-1:0]      out_c2;
    logic [CH_W-1:0]      out_c3;
    logic                 last_pixel;

    mip_scoreboard sb;
    pixel_t        batch [$];
    int            burst_left   = 0;
    int            idle_cycles  = 0;
    int            stall_mode   = 0;
    int            mode_left    = 0;
    int            hold_left    = 0;
    bit            stall_run    = 1'b0;
    int            phases       = 0;

    mipmap_box_downsample_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pix_c0       (pix_c0),
        .pix_c1       (pix_c1),
        .pix_c2       (pix_c2),
        .pix_c3       (pix_c3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_c0       (out_c0),
        .out_c1       (out_c1),
        .out_c2       (out_c2),
        .out_c3       (out_c3),
        .last_pixel   (last_pixel)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Observe register writes and transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                sb.take_pixel({pix_c3, pix_c2, pix_c1, pix_c0});
            end
            if (out_valid && !out_stall)
            begin
                sb.check_pixel({{out_c3, out_c2, out_c1, out_c0}, last_pixel});
            end
        end
    end

    // Watchdog: too long without any transfer or write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en)
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Output back-pressure: free, light, heavy or long on/off runs
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 400);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_left = $urandom_range(1, 30);
                    stall_run = ~stall_run;
                end
                hold_left--;
                out_stall <= stall_run;
            end
        endcase
    end

    // One source pixel transfer; bursts of random length with gaps between
    task automatic send_pixel(input pixel_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 64);
        end
        in_valid <= 1'b1;
        pix_c0   <= p[0];
        pix_c1   <= p[1];
        pix_c2   <= p[2];
        pix_c3   <= p[3];
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        burst_left--;
    endtask

    task automatic send_batch();
        foreach (batch[i])
        begin
            send_pixel(batch[i]);
        end
        batch.delete();
        in_valid <= 1'b0;
    endtask

    // Wait until every box pixel is out, then let write jobs finish
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Back-to-back register writes; sel bit i picks register i
    task automatic write_regs(input bit [3:0] sel, input logic [CFG_W-1:0] fmt_v,
                              input logic [CFG_W-1:0] w_v, input logic [CFG_W-1:0] h_v,
                              input logic [CFG_W-1:0] spare_v);
        logic [CFG_IDX_W-1:0] ids [4];
        logic [CFG_W-1:0]     vals [4];
        ids  = '{REG_PIXEL_FORMAT, REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_SPARE};
        vals = '{fmt_v, w_v, h_v, spare_v};
        for (int i = 0; i < 4; i++)
        begin
            if (sel[i])
            begin
                cfg_write_en <= 1'b1;
                cfg_index    <= ids[i];
                cfg_data     <= vals[i];
                @(posedge clk);
            end
        end
        if (sel != 4'b0000)
        begin
            cfg_write_en <= 1'b0;
        end
        phases++;
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        for (int k = 0; k < NUM_CH; k++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                p[k] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                p[k] = CH_W'($urandom);
            end
        end
        return p;
    endfunction

    // Mostly small even sizes; sometimes odd, tiny or beyond the maximum
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return CFG_W'(1);
                    2:       return CFG_W'(2 * $urandom_range(1, 8) + 1);
                    3:       return '1;
                    default: return CFG_W'($urandom_range(MAX_WIDTH + 1, 8190));
                endcase
            end
            1:       return CFG_W'(2 * $urandom_range(9, 64));
            default: return CFG_W'(2 * $urandom_range(1, 6));
        endcase
    endfunction

    initial
    begin
        bit [3:0]         sel;
        logic [CFG_W-1:0] fmt_v;
        logic [CFG_W-1:0] w_v;
        logic [CFG_W-1:0] h_v;
        logic [CFG_W-1:0] eff_w;
        logic [CFG_W-1:0] eff_h;
        int               left;
        int               count;
        int               sent;
        bit               ok;

        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: a few pixels into row 0, then shrink so the column wraps
        batch = '{pixel_t'(32'hFFFF_FFFF), pixel_t'(32'h0000_0000),
                  pixel_t'(32'hF00F_AA55), pixel_t'(32'hFE01_7F80)};
        send_batch();
        drain();

        // 4x2, four channels: all-max block, then a truncating block
        write_regs(4'b0111, CFG_W'(FMT_FOUR), CFG_W'(4), CFG_W'(2), '0);
        batch = '{pixel_t'(32'hFFFF_FFFF), pixel_t'(32'hFFFF_FFFF),
                  pixel_t'(32'h0003_0201), pixel_t'(32'h0302_0100),
                  pixel_t'(32'hFFFF_FFFF), pixel_t'(32'hFFFF_FFFF),
                  pixel_t'(32'h0303_0303), pixel_t'(32'h0180_00FF)};
        send_batch();
        drain();

        // One channel; odd width and height below the minimum
        write_regs(4'b0111, CFG_W'(FMT_ONE), CFG_W'(3), CFG_W'(1), '0);
        batch = '{pixel_t'(32'h281E_140A), pixel_t'(32'h291F_150B),
                  pixel_t'(32'h2A20_160C), pixel_t'(32'h2B21_170D)};
        send_batch();
        drain();

        // Two channels; zero width
        write_regs(4'b0011, CFG_W'(FMT_TWO), CFG_W'(0), CFG_W'(2), '0);
        batch = '{pixel_t'(32'hFFFF_FFFF), pixel_t'(32'hFFFF_FFFF),
                  pixel_t'(32'hFFFF_FFFF), pixel_t'(32'hFFFF_FFFF)};
        send_batch();
        drain();

        // Unused format code, write to the spare index
        write_regs(4'b1001, CFG_W'(FMT_SPARE), '0, '0, '1);
        batch = '{pixel_t'(32'h00FF_55AA), pixel_t'(32'hFF00_AA55),
                  pixel_t'(32'h807F_01FE), pixel_t'(32'h7F80_FE01)};
        send_batch();
        drain();

        // Widest size (width beyond range saturates): start of the first row
        write_regs(4'b0111, CFG_W'(FMT_FOUR), '1, CFG_W'(2), '0);
        for (int i = 0; i < WIDE_PIXELS; i++)
        begin
            batch.push_back(rand_pixel());
        end
        send_batch();
        drain();

        // Random phases: new settings, then a whole level or a partial run
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            ok = 1'b0;
            for (int t = 0; t < 10 && !ok; t++)
            begin
                sel = 4'($urandom_range(1, 15));
                if ($urandom_range(0, 7) != 0)
                begin
                    sel[3] = 1'b0;
                end
                w_v   = pick_size();
                h_v   = pick_size();
                eff_w = sel[1] ? w_v : sb.width_reg;
                eff_h = sel[2] ? h_v : sb.height_reg;
                ok    = sb.reads_covered(eff_w, eff_h);
            end
            if (!ok)
            begin
                sel   = 4'b0001;
                eff_w = sb.width_reg;
                eff_h = sb.height_reg;
            end
            fmt_v = CFG_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1)
            begin
                fmt_v[CFG_W-1:FMT_W] = (CFG_W - FMT_W)'($urandom);
            end
            write_regs(sel, fmt_v, w_v, h_v, CFG_W'($urandom));

            left = sb.pixels_to_level_end(eff_w, eff_h);
            if (left <= 600 && $urandom_range(0, 3) != 0)
            begin
                count = left;
            end
            else
            begin
                count = $urandom_range(1, 200);
            end
            for (int i = 0; i < count; i++)
            begin
                batch.push_back(rand_pixel());
            end
            send_batch();
            sent += count;
            drain();
        end

        $display("Run covered %0d source pixels and %0d checked box pixels (%0d level ends),",
                 sb.pixels_in, sb.checked, sb.level_ends);
        $display("over %0d register settings with %0d register writes.",
                 phases, sb.reg_writes);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[mipmap_box_downsample_top.f]
rtl/mbd_pkg.sv
rtl/mbd_ram.sv
rtl/mbd_front.sv
rtl/mbd_queue.sv
rtl/mbd_back.sv
rtl/mipmap_box_downsample_top.sv
tb/sv/tb.sv
